@@ hdl/tkfv_pkg.sv @@
package tkfv_pkg;
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int MAX_TOP_DEF = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int VALUE_BITS = 32;
   localparam int FREQ_BITS = 16;
   localparam int TOPCNT_BITS = 5;
   localparam logic [1:0] CSR_TOP_COUNT = 2'd0;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_CMP    = 7'b0000100,
      ST_WRITE  = 7'b0001000,
      ST_SEL    = 7'b0010000,
      ST_INSERT = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   // true if (ca,ka) ranks strictly before (cb,kb)
   function automatic logic ranks_before(input logic [31:0] ca, input logic [31:0] ka,
                                         input logic [31:0] cb, input logic [31:0] kb);
      if (ca != cb) return ca > cb;
      return $signed(ka) < $signed(kb);
   endfunction
endpackage

@@ hdl/tkfv_ram.sv @@
module tkfv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

@@ hdl/top_k_frequent_values.sv @@
// Channel | Direction | Handshake        | Payload
// req     | in        | req_valid/ready  | req_value, req_last
// rsp     | out       | rsp_valid/ready  | rsp_value_res, rsp_frequency, rsp_final_res,
//         |           |                  | rsp_overflow
// csr     | in        | APB psel/penable | top_count at byte 0
//
// Counting: one item walks the table through the table RAM read port, with a read
// step (SCAN) and a compare step (CMP) per entry until a match or the end of the table.
// On last: a second walk inserts each entry into the best list of k (at most MAX_TOP),
// one list slot compared per cycle, then up to k results.
// Reset (synchronous) empties the table by zeroing the fill count; no sweep.
// Stalls on rsp hold the current result; req is not ready until the report ends.
module top_k_frequent_values #(
   parameter int TABLE_ENTRIES = tkfv_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_TOP       = tkfv_pkg::MAX_TOP_DEF,
   parameter int COUNT_BITS    = tkfv_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_value_res,
   output logic [15:0] rsp_frequency,
   output logic        rsp_final_res,
   output logic        rsp_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int NW = $clog2(TABLE_ENTRIES + 1);
   localparam int TW = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int KW = $clog2(MAX_TOP + 1);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   tkfv_pkg::state_type state_ff, state_in;
   logic [4:0]          topc_ff;
   logic [NW-1:0]       used_ff, used_in;
   logic [NW-1:0]       idx_ff, idx_in;
   logic                ovf_ff, ovf_in;
   logic [31:0]         val_ff, val_in;
   logic                last_ff, last_in;
   logic [KW-1:0]       n_ff, n_in, kk_ff, kk_in;
   logic [KW-1:0]       p_ff, p_in;
   logic [31:0]         ckey_ff, ckey_in;
   logic [COUNT_BITS-1:0] ccnt_ff, ccnt_in;
   logic [31:0]         bkey_ff [MAX_TOP];
   logic [COUNT_BITS-1:0] bcnt_ff [MAX_TOP];

   // table RAMs
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [31:0]           key_wd, key_rd;
   logic [COUNT_BITS-1:0] cnt_wd, cnt_rd;

   tkfv_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_keys (
      .clock, .wr_en, .wr_addr, .wr_data(key_wd), .rd_addr, .rd_data(key_rd));
   tkfv_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_ENTRIES)) u_cnts (
      .clock, .wr_en, .wr_addr, .wr_data(cnt_wd), .rd_addr, .rd_data(cnt_rd));

   assign pready = 1'b1;
   assign prdata = (paddr == tkfv_pkg::CSR_TOP_COUNT) ? {27'd0, topc_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) topc_ff <= 5'd1;
      else if (psel && penable && pwrite && paddr == tkfv_pkg::CSR_TOP_COUNT)
         topc_ff <= pwdata[4:0];
   end

   logic [KW-1:0] kk_cfg;
   always_comb begin
      if (topc_ff == 5'd0) kk_cfg = KW'(1);
      else if (32'(topc_ff) > MAX_TOP) kk_cfg = KW'(MAX_TOP);
      else kk_cfg = KW'(topc_ff);
   end

   assign req_ready = (state_ff == tkfv_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == tkfv_pkg::ST_EMIT);
   assign rsp_value_res = bkey_ff[p_ff[TW-1:0]];
   assign rsp_frequency = (32'(bcnt_ff[p_ff[TW-1:0]]) > 32'hFFFF) ? 16'hFFFF
                          : 16'(bcnt_ff[p_ff[TW-1:0]]);
   assign rsp_final_res = (p_ff + KW'(1) == n_ff);
   assign rsp_overflow  = ovf_ff;

   // shared comparator: current entry vs best slot p
   logic better;
   assign better = tkfv_pkg::ranks_before(32'(ccnt_ff), ckey_ff,
                                          32'(bcnt_ff[p_ff[TW-1:0]]), bkey_ff[p_ff[TW-1:0]]);
   logic ins_go;
   assign ins_go = (state_ff == tkfv_pkg::ST_INSERT) && (p_ff < kk_ff);

   always_comb begin
      state_in = state_ff; used_in = used_ff; idx_in = idx_ff; ovf_in = ovf_ff;
      val_in = val_ff; last_in = last_ff; n_in = n_ff; kk_in = kk_ff; p_in = p_ff;
      ckey_in = ckey_ff; ccnt_in = ccnt_ff;
      wr_en = 1'b0; wr_addr = used_ff[AW-1:0]; key_wd = val_ff; cnt_wd = COUNT_BITS'(1);
      rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         tkfv_pkg::ST_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               val_in = req_value; last_in = req_last; state_in = tkfv_pkg::ST_SCAN;
            end
         end
         tkfv_pkg::ST_SCAN: begin
            // issue read of idx, or append/overflow at end of table
            if (idx_ff == used_ff) begin
               if (32'(used_ff) < TABLE_ENTRIES) begin
                  wr_en = 1'b1; used_in = used_ff + NW'(1);
               end else ovf_in = 1'b1;
               state_in = tkfv_pkg::ST_WRITE;
            end else state_in = tkfv_pkg::ST_CMP;
         end
         tkfv_pkg::ST_CMP: begin
            if (key_rd == val_ff) begin
               wr_addr = idx_ff[AW-1:0];
               wr_en = (cnt_rd != CMAX);
               cnt_wd = cnt_rd + COUNT_BITS'(1);
               state_in = tkfv_pkg::ST_WRITE;
            end else begin
               idx_in = idx_ff + NW'(1); state_in = tkfv_pkg::ST_SCAN;
            end
         end
         tkfv_pkg::ST_WRITE: begin
            idx_in = '0; n_in = '0; kk_in = kk_cfg;
            state_in = last_ff ? tkfv_pkg::ST_SEL : tkfv_pkg::ST_IDLE;
         end
         tkfv_pkg::ST_SEL: begin
            // read issued last cycle lands now
            if (idx_ff == used_ff) begin
               p_in = '0; state_in = tkfv_pkg::ST_EMIT;
            end else begin
               state_in = tkfv_pkg::ST_INSERT; p_in = '0;
               ckey_in = key_rd; ccnt_in = cnt_rd;
            end
         end
         tkfv_pkg::ST_INSERT: begin
            if (p_ff < n_ff && !better) p_in = p_ff + KW'(1);
            else begin
               if (p_ff < kk_ff && n_ff < kk_ff) n_in = n_ff + KW'(1);
               idx_in = idx_ff + NW'(1);
               rd_addr = AW'(idx_ff + NW'(1));
               state_in = tkfv_pkg::ST_SEL;
            end
         end
         tkfv_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               if (rsp_final_res) begin
                  used_in = '0; ovf_in = 1'b0; state_in = tkfv_pkg::ST_IDLE;
               end else p_in = p_ff + KW'(1);
            end
         end
         default: state_in = tkfv_pkg::ST_IDLE;
      endcase
      // read of first entry for the selection walk
      if (state_ff == tkfv_pkg::ST_WRITE) rd_addr = '0;
   end

   // insertion shift into best list (all slots at once)
   always_ff @(posedge clock) begin
      if (ins_go && !(p_ff < n_ff && !better)) begin
         for (int j = MAX_TOP - 1; j > 0; j--) begin
            if (j > int'(p_ff)) begin
               bkey_ff[TW'(j)] <= bkey_ff[TW'(j-1)]; bcnt_ff[TW'(j)] <= bcnt_ff[TW'(j-1)];
            end
         end
         bkey_ff[p_ff[TW-1:0]] <= ckey_ff;
         bcnt_ff[p_ff[TW-1:0]] <= ccnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkfv_pkg::ST_IDLE; used_ff <= '0; ovf_ff <= 1'b0;
         idx_ff <= '0; n_ff <= '0; p_ff <= '0; kk_ff <= KW'(1);
      end else begin
         state_ff <= state_in; used_ff <= used_in; ovf_ff <= ovf_in;
         idx_ff <= idx_in; n_ff <= n_in; p_ff <= p_in; kk_ff <= kk_in;
      end
      val_ff <= val_in; last_ff <= last_in; ckey_ff <= ckey_in; ccnt_ff <= ccnt_in;
   end

`ifndef SYNTHESIS
   a_used: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= TABLE_ENTRIES) else $error("fill count beyond table");
   a_n: assert property (@(posedge clock) disable iff (reset)
      n_ff <= kk_ff) else $error("best list over k");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (n_ff != '0)) else $error("empty report");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final_res |=> used_ff == '0 && !ovf_ff)
      else $error("table not emptied");
`endif
endmodule

@@ tb/top_k_frequent_values_tb.sv @@
module top_k_frequent_values_tb;

   localparam int TABLE_SIZE = tkfv_pkg::TABLE_ENTRIES_DEF;
   localparam int TOP_LIMIT  = tkfv_pkg::MAX_TOP_DEF;
   localparam int COUNT_TOP  = (1 << tkfv_pkg::COUNT_BITS_DEF) - 1;

   typedef struct {
      logic signed [31:0] value_res;
      logic [15:0]        frequency;
      logic               final_res;
      logic               overflow;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_value_res;
   logic [15:0] rsp_frequency;
   logic rsp_final_res;
   logic rsp_overflow;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   top_k_frequent_values uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_value_res(rsp_value_res), .rsp_frequency(rsp_frequency),
      .rsp_final_res(rsp_final_res), .rsp_overflow(rsp_overflow),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Model of the frequency table, kept in step with accepted items
   logic signed [31:0] freq_keys[$];
   int unsigned        freq_counts[$];
   logic               freq_dropped;
   logic [4:0]         top_k_reg;

   report_type         pending_reports[$];
   int                 errors;
   int                 burst_left;

   // Count one value; on last, rank the table and queue the report
   task automatic tally_value(input logic signed [31:0] v, input logic lst);
      logic signed [31:0] rk[$];
      int unsigned        rc[$];
      int                 kk, p, found;
      report_type         r;
      found = 0;
      foreach (freq_keys[i]) begin
         if (!found && freq_keys[i] == v) begin
            if (freq_counts[i] < COUNT_TOP) freq_counts[i]++;
            found = 1;
         end
      end
      if (!found) begin
         if (freq_keys.size() < TABLE_SIZE) begin
            freq_keys.insert(freq_keys.size(), v);
            freq_counts.insert(freq_counts.size(), 1);
         end else begin
            freq_dropped = 1'b1;
         end
      end
      if (!lst) return;
      kk = (top_k_reg == 0) ? 1 : (top_k_reg > TOP_LIMIT ? TOP_LIMIT : top_k_reg);
      // insertion rank: count descending, then smaller signed value first
      foreach (freq_keys[i]) begin
         p = 0;
         while (p < rk.size() && (rc[p] > freq_counts[i] ||
                (rc[p] == freq_counts[i] && rk[p] < freq_keys[i])))
            p++;
         if (p < kk) begin
            rk.insert(p, freq_keys[i]);
            rc.insert(p, freq_counts[i]);
            if (rk.size() > kk) begin
               void'(rk.pop_back());
               void'(rc.pop_back());
            end
         end
      end
      foreach (rk[i]) begin
         r.value_res = rk[i];
         r.frequency = (rc[i] > 16'hFFFF) ? 16'hFFFF : rc[i][15:0];
         r.final_res = (i == rk.size() - 1);
         r.overflow  = freq_dropped;
         pending_reports.insert(pending_reports.size(), r);
      end
      freq_keys.delete();
      freq_counts.delete();
      freq_dropped = 1'b0;
   endtask

   // Sender: bursts with random gaps; the valid stays up across back-to-back items
   task automatic send_item(input logic signed [31:0] v, input logic lst);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= lst;
      do @(posedge clock); while (!req_ready);
      tally_value(v, lst);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_top_count(input logic [31:0] k);
      wait_drained();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= tkfv_pkg::CSR_TOP_COUNT; pwdata <= k;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      top_k_reg = k[4:0];
   endtask

   // Receiver: stalls in a pattern of its own, with quiet stretches
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if ((phase / 64) % 3 == 2) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Result checker against the oldest pending item
   always @(posedge clock) begin
      report_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result value=%0d freq=%0d", $time,
                     rsp_value_res, rsp_frequency);
            errors++;
         end else begin
            e = pending_reports.pop_front();
            if (rsp_value_res !== e.value_res) begin
               $display("%0t: value_res exp %0d got %0d", $time, e.value_res, rsp_value_res);
               errors++;
            end
            if (rsp_frequency !== e.frequency) begin
               $display("%0t: frequency exp %0d got %0d", $time, e.frequency, rsp_frequency);
               errors++;
            end
            if (rsp_final_res !== e.final_res) begin
               $display("%0t: final_res exp %0b got %0b", $time, e.final_res, rsp_final_res);
               errors++;
            end
            if (rsp_overflow !== e.overflow) begin
               $display("%0t: overflow exp %0b got %0b", $time, e.overflow, rsp_overflow);
               errors++;
            end
         end
      end
   end

   // Directed: field extremes, ties, single-item run, k of one
   task automatic test_extremes();
      send_item(32'sh7FFFFFFF, 1'b0);
      send_item(32'sh80000000, 1'b0);
      send_item(32'sh00000000, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sh55555555, 1'b0);
      send_item(32'shAAAAAAAA, 1'b0);
      send_item(-32'sd1, 1'b1);
      send_item(32'sd5, 1'b1);
   endtask

   // More distinct values than the table holds; later repeats still count
   task automatic test_table_full();
      for (int i = 0; i < TABLE_SIZE + 4; i++) send_item(i * 3 - 200, 1'b0);
      send_item(-200, 1'b0);
      send_item(-197, 1'b1);
   endtask

   // Random runs of small alphabets so repeats and ties are common
   task automatic test_random_runs(input int items);
      int len, span, base;
      while (items > 0) begin
         len  = $urandom_range(1, 25);
         if (len > items) len = items;
         span = $urandom_range(1, 20);
         base = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40) - 20;
         for (int i = 0; i < len; i++) begin
            send_item((i == len - 1 || $urandom_range(0, 9) != 0) ?
                      base + $urandom_range(0, span - 1) : $urandom, i == len - 1);
            items--;
         end
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
   endtask

   initial begin
      errors = 0;
      burst_left = 0;
      freq_dropped = 1'b0;
      top_k_reg = 5'd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      write_top_count(32'd16);
      test_extremes();
      write_top_count(32'd0);
      test_extremes();
      write_top_count(32'd31);
      test_extremes();
      write_top_count(32'd3);
      test_table_full();
      write_top_count(32'd16);
      test_random_runs(12);
      write_top_count(32'd5);
      test_random_runs(12);
      write_top_count(32'd1);
      test_random_runs(12);
      wait_drained();
      repeat (1000) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("** top_k_frequent_values: PASSED **");
      end else begin
         $display("** top_k_frequent_values: FAILED **");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("** top_k_frequent_values: FAILED **");
      $finish;
   end
endmodule

@@ top_k_frequent_values.f @@
hdl/tkfv_pkg.sv
hdl/tkfv_ram.sv
hdl/top_k_frequent_values.sv
tb/top_k_frequent_values_tb.sv
